### hw/rtl/ietlv_pkg.sv
// ----------------------------------------------------------------------------
// ietlv_pkg
// Types, register indexes and reset values shared by the information-element
// scanner.
// ----------------------------------------------------------------------------
package ietlv_pkg;

   localparam int OUI_BYTES_DEF = 8;

   localparam int REG_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [REG_IDX_W-1:0] REG_TARGET_ID   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MATCH_OUI   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_OUI_LEN     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_OUI_PATTERN = 2'd3;

   localparam logic [7:0] TARGET_ID_RST = 8'd221;
   localparam logic       MATCH_OUI_RST = 1'b0;
   localparam logic [3:0] OUI_LEN_RST   = 4'd3;
   localparam logic [CSR_DATA_W-1:0] OUI_PATTERN_RST = '0;

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

endpackage

### hw/rtl/info_element_tlv_scanner_unit.sv
// ----------------------------------------------------------------------------
// info_element_tlv_scanner_unit
// Scans an information-element buffer byte by byte for a target element id
// with an optional OUI prefix, and checks that the buffer is well formed.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one buffer byte per word in req_tdata, with
// req_tlast marking the final byte of a buffer. Every byte updates the parse
// state in the cycle it is accepted; no result word is produced except for a
// byte with req_tlast set. That word is registered and appears on the rsp
// channel in the cycle after the byte is accepted; it carries found, the
// matching element's offset and the well-formed flag. The parse state is
// then cleared for the next buffer.
// A byte can be accepted in every cycle unless the output stalls. The
// result register is the only buffer on the output: while a result waits
// and rsp_tready is low, req_tready is low too until the word is taken.
// The csr port writes the target id, the OUI enable, the OUI length and the
// OUI pattern; it should only be used while no buffer is in progress.
// Reset is synchronous: it restores the register defaults, clears the parse
// state and empties the result register.
// ----------------------------------------------------------------------------
module info_element_tlv_scanner_unit #(
   parameter int OUI_BYTES = ietlv_pkg::OUI_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [7:0] data_byte
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tlast,
   // rsp_tdata: [0] found, [16:1] match_offset, [17] well_formed, [23:18] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [ietlv_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [ietlv_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] OUI_MAX = 4'(OUI_BYTES);

   logic [7:0]  target_id_ff;
   logic        match_oui_ff;
   logic [3:0]  oui_len_ff;
   logic [63:0] oui_pattern_ff;

   logic [15:0]          pos_ff, pos_in;
   ietlv_pkg::phase_type phase_ff, phase_in;
   logic [15:0]          start_ff, start_in;
   logic [7:0]           remain_ff, remain_in;
   logic [3:0]           cidx_ff, cidx_in;
   logic                 cok_ff, cok_in;
   logic                 cand_ff, cand_in;
   logic                 found_ff, found_in;
   logic [15:0]          mpos_ff, mpos_in;
   logic                 stop_ff, stop_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [17:0] rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       done;
   logic       elem_ok;
   logic [3:0] eff_len;
   logic [7:0] pat_byte;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   assign eff_len  = (oui_len_ff > OUI_MAX) ? OUI_MAX : oui_len_ff;
   assign pat_byte = oui_pattern_ff[8*cidx_ff[2:0] +: 8];

   always_comb begin
      pos_in    = pos_ff + 16'd1;
      phase_in  = phase_ff;
      start_in  = start_ff;
      remain_in = remain_ff;
      cidx_in   = cidx_ff;
      cok_in    = cok_ff;
      cand_in   = cand_ff;
      found_in  = found_ff;
      mpos_in   = mpos_ff;
      stop_in   = stop_ff;
      done      = 1'b0;
      elem_ok   = 1'b0;
      rsp_data_in = rsp_data_ff;

      case (phase_ff)
         ietlv_pkg::PH_ID: begin
            start_in = pos_ff;
            cand_in  = !stop_ff && (req_tdata == target_id_ff);
            phase_in = ietlv_pkg::PH_LEN;
         end
         ietlv_pkg::PH_LEN: begin
            remain_in = req_tdata;
            cidx_in   = 4'd0;
            cok_in    = 1'b1;
            if (req_tdata == 8'd0) begin
               done = 1'b1;
            end else begin
               phase_in = ietlv_pkg::PH_BODY;
            end
         end
         ietlv_pkg::PH_BODY: begin
            if (cand_ff && match_oui_ff && (cidx_ff < eff_len)) begin
               if (pat_byte != req_tdata) begin
                  cok_in = 1'b0;
               end
               cidx_in = cidx_ff + 4'd1;
            end
            remain_in = remain_ff - 8'd1;
            done      = (remain_in == 8'd0);
         end
         default: begin
            phase_in = ietlv_pkg::PH_ID;
         end
      endcase

      if (done) begin
         elem_ok = !match_oui_ff || (cok_in && (cidx_in >= eff_len));
         if (cand_ff && !stop_ff && elem_ok) begin
            found_in = 1'b1;
            mpos_in  = start_ff;
            stop_in  = 1'b1;
         end
         cand_in  = 1'b0;
         phase_in = ietlv_pkg::PH_ID;
      end

      if (req_tlast) begin
         rsp_data_in = {phase_in == ietlv_pkg::PH_ID,
                        found_in ? mpos_in : 16'd0,
                        found_in};
         pos_in    = 16'd0;
         phase_in  = ietlv_pkg::PH_ID;
         start_in  = 16'd0;
         remain_in = 8'd0;
         cidx_in   = 4'd0;
         cok_in    = 1'b1;
         cand_in   = 1'b0;
         found_in  = 1'b0;
         mpos_in   = 16'd0;
         stop_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff   <= ietlv_pkg::TARGET_ID_RST;
         match_oui_ff   <= ietlv_pkg::MATCH_OUI_RST;
         oui_len_ff     <= ietlv_pkg::OUI_LEN_RST;
         oui_pattern_ff <= ietlv_pkg::OUI_PATTERN_RST;
      end else if (csr_we) begin
         case (csr_index)
            ietlv_pkg::REG_TARGET_ID:   target_id_ff   <= csr_wdata[7:0];
            ietlv_pkg::REG_MATCH_OUI:   match_oui_ff   <= csr_wdata[0];
            ietlv_pkg::REG_OUI_LEN:     oui_len_ff     <= csr_wdata[3:0];
            ietlv_pkg::REG_OUI_PATTERN: oui_pattern_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 16'd0;
         phase_ff     <= ietlv_pkg::PH_ID;
         start_ff     <= 16'd0;
         remain_ff    <= 8'd0;
         cidx_ff      <= 4'd0;
         cok_ff       <= 1'b1;
         cand_ff      <= 1'b0;
         found_ff     <= 1'b0;
         mpos_ff      <= 16'd0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            pos_ff    <= pos_in;
            phase_ff  <= phase_in;
            start_ff  <= start_in;
            remain_ff <= remain_in;
            cidx_ff   <= cidx_in;
            cok_ff    <= cok_in;
            cand_ff   <= cand_in;
            found_ff  <= found_in;
            mpos_ff   <= mpos_in;
            stop_ff   <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_search_stops_on_match: assert property (@(posedge clock) disable iff (reset)
      stop_ff == found_ff)
      else $error("search stop flag disagrees with match flag");

   a_offset_zero_without_match: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (mpos_ff == 16'd0))
      else $error("match offset set without a match");

   a_compare_index_bounded: assert property (@(posedge clock) disable iff (reset)
      cidx_ff <= OUI_MAX)
      else $error("OUI compare index beyond the OUI length");

   a_result_from_last_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_tlast))
      else $error("result word without a final buffer byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (pos_ff == 16'd0) && (phase_ff == ietlv_pkg::PH_ID))
      else $error("parse state not cleared after the final byte");
`endif

endmodule
